### sv/one_wire_bus_master_unit_defines.svh
// Assertion macros for the one-wire bus master unit.
// Used by the port checker; the sampling clock is clk, disabled while rst_n is low.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// same-cycle implication
`define OWBM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owbm check failed");

// next-cycle implication
`define OWBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owbm check failed");

`endif

### sv/owbm_pkg.sv
// Shared constants and types for the one-wire bus master unit.
// No dependencies.
package owbm_pkg;

    localparam int TIMER_WIDTH_DEF = 10;
    localparam int CFG_DATA_W      = 10;
    localparam int NUM_REGS        = 8;
    localparam int CFG_IDX_W       = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TOTAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W1_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SLOT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY    = 3'd7;

    localparam logic [CFG_DATA_W-1:0] REG_RESET_VALS [NUM_REGS] = '{
        10'd480, 10'd1010, 10'd11, 10'd67, 10'd6, 10'd12, 10'd62, 10'd1
    };

    // command codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } result_t;

endpackage

### sv/one_wire_bus_master_unit.sv
// One-wire bus master unit: each input item is one microsecond tick carrying an
// optional command and the sampled line level; each tick yields one result item with
// the line drive, busy, done and the read byte. An item is taken every clock unless
// m_tready holds back a waiting result with the input register full. It is registered,
// worked out by the sequencer in one pass, and its result lands in an output register
// when consumed, which lets the next item in while a result waits. Commands are only
// honoured while idle. Unchecked user rule: write timing registers through the cfg port
// while no items are in flight. Depends on owbm_pkg, owbm_cfg_regs and owbm_sequencer.
module one_wire_bus_master_unit #(
    parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // write_data[7:0], line_sample[8]
    input  logic [1:0]                      s_tuser,   // operation[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata    // drive_low, busy_res, done_res,
                                                       // read_data[10:3]
);

    localparam int CNT_W = (TIMER_WIDTH < owbm_pkg::CFG_DATA_W) ?
                           TIMER_WIDTH : owbm_pkg::CFG_DATA_W;

    logic [owbm_pkg::NUM_REGS-1:0][CNT_W-1:0] timing;

    logic              in_valid_reg;
    logic [1:0]        op_reg;
    logic [7:0]        wdata_reg;
    logic              line_reg;
    logic              out_valid_reg;
    owbm_pkg::result_t out_reg;
    owbm_pkg::result_t result;
    logic              consume;

    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    owbm_cfg_regs #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .timing   (timing)
    );

    owbm_sequencer #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (consume),
        .operation   (op_reg),
        .write_data  (wdata_reg),
        .line_sample (line_reg),
        .timing      (timing),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end

            if (consume)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tuser;
            wdata_reg <= s_tdata[7:0];
            line_reg  <= s_tdata[8];
        end
        if (consume)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

endmodule

### sv/owbm_cfg_regs.sv
// Timing register file for the one-wire bus master unit.
// Depends on owbm_pkg.
module owbm_cfg_regs #(
    parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [owbm_pkg::NUM_REGS-1:0][((TIMER_WIDTH < owbm_pkg::CFG_DATA_W) ?
                 TIMER_WIDTH : owbm_pkg::CFG_DATA_W)-1:0] timing
);

    localparam int CNT_W = (TIMER_WIDTH < owbm_pkg::CFG_DATA_W) ?
                           TIMER_WIDTH : owbm_pkg::CFG_DATA_W;

    logic [owbm_pkg::NUM_REGS-1:0][CNT_W-1:0] timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < owbm_pkg::NUM_REGS; i++)
            begin
                timing_reg[i] <= owbm_pkg::REG_RESET_VALS[i][CNT_W-1:0];
            end
        end
        else if (cfg_we)
        begin
            timing_reg[cfg_addr] <= cfg_data[CNT_W-1:0];
        end
    end

    assign timing = timing_reg;

endmodule

### sv/owbm_sequencer.sv
// Bus sequencer: operation state and the per-tick slot timing.
// Depends on owbm_pkg; fed by owbm_cfg_regs.
module owbm_sequencer #(
    parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [1:0]           operation,
    input  logic [7:0]           write_data,
    input  logic                 line_sample,
    input  logic [owbm_pkg::NUM_REGS-1:0][((TIMER_WIDTH < owbm_pkg::CFG_DATA_W) ?
                 TIMER_WIDTH : owbm_pkg::CFG_DATA_W)-1:0] timing,
    output owbm_pkg::result_t    result
);

    localparam int CNT_W = (TIMER_WIDTH < owbm_pkg::CFG_DATA_W) ?
                           TIMER_WIDTH : owbm_pkg::CFG_DATA_W;
    localparam logic [2:0] BIT_LAST = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESET,
        PH_WRITE,
        PH_READ,
        PH_RECOVER
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [1:0]       kind_reg, kind_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic [2:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;

    phase_t           ph;
    logic [1:0]       kind;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] tick_next;
    logic [CNT_W-1:0] low_time;
    logic [2:0]       bitn;
    logic [7:0]       sb;
    logic             slot_end;
    phase_t           data_phase;

    always_comb
    begin
        ph   = phase_reg;
        kind = kind_reg;
        slot = slot_reg;
        bitn = bit_reg;
        sb   = shift_reg;

        // a command while idle is handled as tick 0 of its operation
        if (phase_reg == PH_IDLE && operation != owbm_pkg::OP_TICK)
        begin
            case (operation)
                owbm_pkg::OP_RESET: ph = PH_RESET;
                owbm_pkg::OP_WRITE: ph = PH_WRITE;
                owbm_pkg::OP_READ:  ph = PH_READ;
                default:            ph = PH_IDLE;
            endcase
            kind = operation;
            slot = '0;
            bitn = '0;
            sb   = (operation == owbm_pkg::OP_WRITE) ? write_data : 8'd0;
        end

        tick_next  = slot + 1'b1;
        data_phase = (kind == owbm_pkg::OP_READ) ? PH_READ : PH_WRITE;
        low_time   = sb[0] ? timing[owbm_pkg::REG_W1_LOW] : timing[owbm_pkg::REG_WRITE_SLOT];

        phase_next = ph;
        kind_next  = kind;
        slot_next  = slot;
        bit_next   = bitn;
        shift_next = sb;
        slot_end   = 1'b0;
        result     = '0;
        result.busy_res = (ph != PH_IDLE);

        case (ph)
            PH_RESET:
            begin
                result.drive_low = (slot < timing[owbm_pkg::REG_RESET_LOW]);
                slot_next = tick_next;
                if (tick_next >= timing[owbm_pkg::REG_RESET_TOTAL])
                begin
                    phase_next      = PH_IDLE;
                    result.done_res = 1'b1;
                end
            end
            PH_WRITE:
            begin
                result.drive_low = (slot < low_time);
                slot_next = tick_next;
                if (tick_next >= timing[owbm_pkg::REG_WRITE_SLOT])
                begin
                    shift_next = sb >> 1;
                    slot_end   = 1'b1;
                end
            end
            PH_READ:
            begin
                result.drive_low = (slot < timing[owbm_pkg::REG_READ_LOW]);
                if (slot == timing[owbm_pkg::REG_READ_SAMPLE] && line_sample)
                begin
                    shift_next = sb | (8'd1 << bitn);
                end
                slot_next = tick_next;
                if (tick_next >= timing[owbm_pkg::REG_READ_SLOT])
                begin
                    slot_end = 1'b1;
                end
            end
            PH_RECOVER:
            begin
                slot_next = tick_next;
                if (tick_next >= timing[owbm_pkg::REG_RECOVERY])
                begin
                    slot_next  = '0;
                    phase_next = data_phase;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (slot_end)
        begin
            if (bitn == BIT_LAST)
            begin
                phase_next      = PH_IDLE;
                result.done_res = 1'b1;
                if (ph == PH_READ)
                begin
                    result.read_data = shift_next;
                end
            end
            else
            begin
                bit_next   = bitn + 1'b1;
                slot_next  = '0;
                phase_next = (timing[owbm_pkg::REG_RECOVERY] == '0) ? data_phase : PH_RECOVER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= '0;
            slot_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            slot_reg  <= slot_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
        end
    end

endmodule

### sv/owbm_port_checker.sv
// Port-level checks for the one-wire bus master unit, bound to the top level.
// Depends on one_wire_bus_master_unit_defines.svh.
`include "one_wire_bus_master_unit_defines.svh"

module owbm_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `OWBM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `OWBM_ASSERT_IMPL(a_done_busy, m_tvalid && m_tdata[2], m_tdata[1])
    `OWBM_ASSERT_IMPL(a_drive_busy, m_tvalid && m_tdata[0], m_tdata[1])
    `OWBM_ASSERT_IMPL(a_rdata_done, m_tvalid && (m_tdata[10:3] != 8'd0), m_tdata[2])

endmodule

bind one_wire_bus_master_unit owbm_port_checker u_owbm_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
